@@ hw/rtl/lrt_pkg.sv @@
// Shared types, constants and a helper function for the LWMA-3 difficulty retarget block.
// Used by the controller, the datapath and the top level.
package lrt_pkg;

	localparam int CNT_W     = 7;
	localparam int SOLVE_W   = 24;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 64;
	localparam int WORD_W    = 256;

	localparam int WINDOW_LENGTH_DEF    = 60;
	localparam int MAX_SOLVE_FACTOR_DEF = 6;
	localparam int MIN_SOLVE_FACTOR_DEF = 6;

	// T*N/20 as ((T*N >> 2) * ceil(2^25 / 5)) >> 25, exact while T*N stays below 2^24
	localparam logic [22:0] MINW_RECIP = 23'd6710887;

	localparam logic [16:0]  SPACING_RESET = 17'd120;
	localparam logic [255:0] LIMIT_RESET   = {32'h0, {224{1'b1}}};

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_SPACING = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT0  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT1  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT2  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT3  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_GUARD   = 3'd6;

	// result status codes
	localparam logic [1:0] ST_COMPUTED = 2'd0;
	localparam logic [1:0] ST_SHORT    = 2'd1;
	localparam logic [1:0] ST_OVERRUN  = 2'd2;

	typedef enum logic [0:0] {
		DIV_AVG  = 1'b0,
		DIV_NUM  = 1'b1
	} div_sel_t;

	typedef struct packed {
		logic       accept;
		logic       prep;
		logic       set_status;
		logic [1:0] status_code;
		logic       div_start;
		div_sel_t   div_sel;
		logic       load_minw;
		logic       load_avg;
		logic       mul_step;
		logic [3:0] mul_idx;
		logic       load_nt;
		logic       floor_calc;
		logic       clamp;
		logic       load_limit;
		logic       norm_step;
		logic       load_out;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic overrun;
		logic short_win;
		logic norm_done;
	} stat_t;

	typedef struct packed {
		logic [255:0] value;
		logic         neg;
		logic         ovf;
	} expand_t;

	// compact form to a 256-bit target; bits shifted past the top are lost
	function automatic expand_t expand_compact(input logic [31:0] bits);
		expand_t    r;
		logic [7:0] size;
		logic [22:0] word;
		logic [7:0] sh;
		size = bits[31:24];
		word = bits[22:0];
		sh = size - 8'd3;
		r.value = '0;
		case (size)
			8'd0: r.value = '0;
			8'd1: r.value = 256'(word >> 16);
			8'd2: r.value = 256'(word >> 8);
			8'd3: r.value = 256'(word);
			default: begin
				if (sh >= 8'd32)
					r.value = '0;
				else
					r.value = 256'(word) << {sh[4:0], 3'b000};
			end
		endcase
		r.neg = (word != 23'd0) && bits[23];
		r.ovf = (word != 23'd0) && ((size > 8'd34) ||
			((word > 23'hff) && (size > 8'd33)) ||
			((word > 23'hffff) && (size > 8'd32)));
		return r;
	endfunction

endpackage

@@ hw/rtl/lwma3_difficulty_retarget_top.sv @@
// Top level of the LWMA-3 difficulty retarget block.
// Depends on lrt_pkg, lrt_ctrl, lrt_dp (and lrt_div below it).
//
// Usage:
//   Slave stream: one beat per anchor or block. tuser is the kind (0 anchor,
//   1 block), tlast marks the newest block of the window. An anchor clears the
//   window and stores the parent time; blocks follow oldest first.
//   Master stream: one result beat for each block beat with tlast set.
//   Configuration: write enable, register index, 64-bit data; write only
//   while no result is in progress.
// Flow:
//   Anchors and non-last blocks are taken one per cycle. After a last block
//   a computed result is formed by the T*N/20 floor by reciprocal multiply,
//   two passes of the 256-step restoring divider (average target, final
//   quotient), 16 partial products, floor and clamp, then up to 32 byte
//   shifts of the compact encoder. Limit results (short window or overrun)
//   go from the limit register straight to the encoder. tready stays low
//   until the result beat is taken.
// Reset: clears the window, restores the register defaults; no clearing pass.
// Stall: the result beat holds on the master side while tready is low, and
//   no new input beat is accepted meanwhile.
module lwma3_difficulty_retarget_top
	import lrt_pkg::*;
#(
	parameter int WINDOW_LENGTH    = WINDOW_LENGTH_DEF,
	parameter int MAX_SOLVE_FACTOR = MAX_SOLVE_FACTOR_DEF,
	parameter int MIN_SOLVE_FACTOR = MIN_SOLVE_FACTOR_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write port
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [CFG_DAT_W-1:0] cfg_wdata,
	// input beats
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [95:0]          s_tdata,   // timestamp, compact_bits, height, pad
	input  logic                 s_tuser,   // action
	input  logic                 s_tlast,   // last
	// result beats
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [39:0]          m_tdata,   // target_compact, blocks_used, pad
	output logic [1:0]           m_tuser    // status
);

	cmd_t        cmd;
	stat_t       st;
	logic [31:0] target_compact;
	logic [1:0]  status;
	logic [5:0]  blocks_used;

	// sequence the steps of a result
	lrt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.action   (s_tuser),
		.last     (s_tlast),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.st       (st)
	);

	// accumulate the window and work out the target
	lrt_dp #(
		.WINDOW_LENGTH    (WINDOW_LENGTH),
		.MAX_SOLVE_FACTOR (MAX_SOLVE_FACTOR),
		.MIN_SOLVE_FACTOR (MIN_SOLVE_FACTOR)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_addr       (cfg_addr),
		.cfg_wdata      (cfg_wdata),
		.action         (s_tuser),
		.timestamp      (s_tdata[31:0]),
		.compact_bits   (s_tdata[63:32]),
		.height_in      (s_tdata[94:64]),
		.cmd            (cmd),
		.st             (st),
		.target_compact (target_compact),
		.status         (status),
		.blocks_used    (blocks_used)
	);

	// pack the result beat
	assign m_tdata = {2'b00, blocks_used, target_compact};
	assign m_tuser = status;

endmodule

@@ hw/rtl/lrt_div.sv @@
// Restoring divider, one quotient bit per cycle: 256-bit dividend by 64-bit divisor.
// A zero divisor yields all ones. Depends on nothing else.
module lrt_div (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [255:0] dividend,
	input  logic [63:0]  divisor,
	output logic         busy,
	output logic         done,
	output logic [255:0] quotient
);

	logic [255:0] dq_q;
	logic [63:0]  rem_q;
	logic [63:0]  d_q;
	logic [7:0]   cnt_q;
	logic         busy_q;
	logic         done_q;
	logic [64:0]  trial;
	logic [64:0]  diff;
	logic         ge;

	assign trial = {rem_q, dq_q[255]};
	assign diff  = trial - {1'b0, d_q};
	assign ge    = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 8'd1;
				if (cnt_q == 8'd255) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			d_q   <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[63:0] : trial[63:0];
			dq_q  <= {dq_q[254:0], ge};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = dq_q;

endmodule

@@ hw/rtl/lrt_dp.sv @@
// Datapath: configuration registers, window accumulators, divider, multiplier,
// clamp and compact encoder. Depends on lrt_pkg and lrt_div.
module lrt_dp
	import lrt_pkg::*;
#(
	parameter int WINDOW_LENGTH    = WINDOW_LENGTH_DEF,
	parameter int MAX_SOLVE_FACTOR = MAX_SOLVE_FACTOR_DEF,
	parameter int MIN_SOLVE_FACTOR = MIN_SOLVE_FACTOR_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [CFG_DAT_W-1:0] cfg_wdata,
	input  logic                 action,
	input  logic [31:0]          timestamp,
	input  logic [31:0]          compact_bits,
	input  logic [30:0]          height_in,
	input  cmd_t                 cmd,
	output stat_t                st,
	output logic [31:0]          target_compact,
	output logic [1:0]           status,
	output logic [5:0]           blocks_used
);

	localparam logic [5:0] MAXF = 6'(MAX_SOLVE_FACTOR);
	localparam logic [5:0] MINF = 6'(MIN_SOLVE_FACTOR);
	localparam logic [CNT_W-1:0] WLEN = CNT_W'(WINDOW_LENGTH);

	// configuration
	logic [16:0]  spacing_q;
	logic [255:0] limit_q;
	logic [31:0]  floor_cmp_q;
	logic [30:0]  guard_q;

	// window state
	logic [CNT_W-1:0]   count_q;
	logic [31:0]        prev_q;
	logic signed [63:0] wtotal_q;
	logic [15:0]        wcount_q;
	logic [255:0]       tsum_q;
	logic               overrun_q;
	logic [30:0]        height_q;

	// result computation
	logic [32:0]  tw_q;
	logic [23:0]  tn_q;
	logic [63:0]  wsum_q;
	logic [255:0] avg_q;
	logic [255:0] acc_q;
	logic [255:0] nt_q;
	logic [255:0] floor_q;
	logic [255:0] norm_q;
	logic [5:0]   size_q;
	logic [31:0]  out_compact_q;
	logic [1:0]   out_status_q;

	// accumulation
	logic signed [32:0]      span;
	logic [22:0]             hi_u;
	logic [22:0]             lo_u;
	logic signed [32:0]      solve_c;
	logic signed [SOLVE_W-1:0] solve24;
	logic [CNT_W-1:0]        weight;
	logic signed [31:0]      wprod;
	expand_t                 blk_ex;

	assign span    = $signed({1'b0, timestamp}) - $signed({1'b0, prev_q});
	assign hi_u    = 23'(MAXF * spacing_q);
	assign lo_u    = 23'(MINF * spacing_q);
	assign solve_c = (span > $signed({10'b0, hi_u})) ? $signed({10'b0, hi_u}) :
		(span < -$signed({10'b0, lo_u})) ? -$signed({10'b0, lo_u}) : span;
	assign solve24 = solve_c[SOLVE_W-1:0];
	assign weight  = count_q + CNT_W'(1);
	assign wprod   = $signed({1'b0, weight}) * solve24;
	assign blk_ex  = expand_compact(compact_bits);

	// minimum weighted sum T*N/20 by reciprocal multiply
	logic [44:0] minw_prod;
	logic [63:0] minw;

	assign minw_prod = {23'b0, tn_q[23:2]} * {22'b0, MINW_RECIP};
	assign minw      = 64'(minw_prod[44:25]);

	// divider
	logic         div_busy;
	logic         div_done;
	logic [255:0] div_q;
	logic [255:0] div_a;
	logic [63:0]  div_b;

	always_comb begin
		case (cmd.div_sel)
			DIV_AVG: begin
				div_a = tsum_q;
				div_b = 64'(count_q);
			end
			DIV_NUM: begin
				div_a = acc_q;
				div_b = 64'(tw_q);
			end
			default: begin
				div_a = '0;
				div_b = '0;
			end
		endcase
	end

	lrt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_q)
	);

	// multiply step: one 32x32 partial product
	logic [31:0]  mul_a;
	logic [31:0]  mul_b;
	logic [63:0]  mul_p;
	logic [3:0]   mul_k;
	logic [255:0] mul_sh;

	assign mul_a  = avg_q[{cmd.mul_idx[3:1], 5'b00000} +: 32];
	assign mul_b  = wsum_q[{cmd.mul_idx[0], 5'b00000} +: 32];
	assign mul_p  = mul_a * mul_b;
	assign mul_k  = {1'b0, cmd.mul_idx[3:1]} + {3'b000, cmd.mul_idx[0]};
	assign mul_sh = 256'(mul_p) << {mul_k, 5'b00000};

	// operating floor
	expand_t op_ex;
	logic    use_op;
	logic [255:0] nt_c;

	assign op_ex  = expand_compact(floor_cmp_q);
	assign use_op = (floor_cmp_q != 32'd0) && (guard_q != 31'd0) &&
		(height_q > guard_q) && !op_ex.neg && !op_ex.ovf &&
		(op_ex.value != '0) && (op_ex.value < limit_q);
	assign nt_c   = (nt_q > floor_q) ? floor_q : nt_q;

	// compact encoder
	logic [23:0] mant24;
	logic [7:0]  size8;
	logic [31:0] compact_c;

	assign mant24    = norm_q[255:232];
	assign size8     = {2'b00, size_q};
	assign compact_c = mant24[23] ? {size8 + 8'd1, 8'h00, norm_q[255:240]} :
		{size8, 1'b0, mant24[22:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spacing_q   <= SPACING_RESET;
			limit_q     <= LIMIT_RESET;
			floor_cmp_q <= '0;
			guard_q     <= '0;
			count_q     <= '0;
			prev_q      <= '0;
			wtotal_q    <= '0;
			wcount_q    <= '0;
			tsum_q      <= '0;
			overrun_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_SPACING: spacing_q <= cfg_wdata[16:0];
					REG_LIMIT0:  limit_q[63:0] <= cfg_wdata;
					REG_LIMIT1:  limit_q[127:64] <= cfg_wdata;
					REG_LIMIT2:  limit_q[191:128] <= cfg_wdata;
					REG_LIMIT3:  limit_q[255:192] <= cfg_wdata;
					REG_FLOOR:   floor_cmp_q <= cfg_wdata[31:0];
					REG_GUARD:   guard_q <= cfg_wdata[30:0];
					default: ;
				endcase
			end
			if (cmd.accept) begin
				if (!action) begin
					count_q   <= '0;
					wtotal_q  <= '0;
					wcount_q  <= '0;
					tsum_q    <= '0;
					overrun_q <= 1'b0;
					prev_q    <= timestamp;
				end else if (count_q >= WLEN) begin
					overrun_q <= 1'b1;
				end else begin
					wtotal_q <= wtotal_q + 64'(wprod);
					wcount_q <= wcount_q + 16'(weight);
					tsum_q   <= tsum_q + blk_ex.value;
					prev_q   <= timestamp;
					count_q  <= weight;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept)
			height_q <= height_in;
		if (cmd.prep) begin
			tw_q <= 33'(spacing_q * wcount_q);
			tn_q <= 24'(spacing_q * count_q);
		end
		if (cmd.set_status)
			out_status_q <= cmd.status_code;
		if (cmd.load_minw)
			wsum_q <= (wtotal_q < $signed(minw)) ? minw : wtotal_q;
		if (cmd.load_avg) begin
			avg_q <= div_q;
			acc_q <= '0;
		end
		if (cmd.mul_step)
			acc_q <= acc_q + mul_sh;
		if (cmd.load_nt)
			nt_q <= div_q;
		if (cmd.floor_calc)
			floor_q <= use_op ? op_ex.value : limit_q;
		if (cmd.clamp) begin
			norm_q <= (nt_c == '0) ? 256'd1 : nt_c;
			size_q <= 6'd32;
		end else if (cmd.load_limit) begin
			norm_q <= limit_q;
			size_q <= 6'd32;
		end else if (cmd.norm_step) begin
			norm_q <= {norm_q[247:0], 8'h00};
			size_q <= size_q - 6'd1;
		end
		if (cmd.load_out)
			out_compact_q <= compact_c;
	end

	assign st.div_done  = div_done;
	assign st.overrun   = overrun_q;
	assign st.short_win = count_q <= CNT_W'(1);
	assign st.norm_done = (norm_q[255:248] != 8'h00) || (size_q == 6'd0);

	assign target_compact = out_compact_q;
	assign status         = out_status_q;
	assign blocks_used    = count_q[5:0];

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !div_busy)
		else $error("divider started while busy");
	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |=> !div_done)
		else $error("divider done held for two cycles");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= WLEN)
		else $error("block count beyond window");
`endif

endmodule

@@ hw/rtl/lrt_ctrl.sv @@
// Controller: handshakes and the sequence of datapath steps for one result.
// Depends on lrt_pkg.
module lrt_ctrl
	import lrt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	input  logic action,
	input  logic last,
	output logic s_tready,
	output logic m_tvalid,
	input  logic m_tready,
	output cmd_t cmd,
	input  stat_t st
);

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_PREP  = 11'b00000000010,
		S_MINW  = 11'b00000000100,
		S_AVG   = 11'b00000001000,
		S_MUL   = 11'b00000010000,
		S_DIVGO = 11'b00000100000,
		S_DIVN  = 11'b00001000000,
		S_FLOOR = 11'b00010000000,
		S_CLAMP = 11'b00100000000,
		S_NORM  = 11'b01000000000,
		S_OUT   = 11'b10000000000
	} state_t;

	state_t     state_q;
	state_t     state_d;
	logic [3:0] mul_q;
	logic       acc;

	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = state_q == S_OUT;
	assign acc      = s_tvalid && s_tready;

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.accept  = acc;
		cmd.mul_idx = mul_q;
		case (state_q)
			S_IDLE: begin
				if (acc && action && last)
					state_d = S_PREP;
			end
			S_PREP: begin
				cmd.prep       = 1'b1;
				cmd.set_status = 1'b1;
				if (st.overrun) begin
					cmd.status_code = ST_OVERRUN;
					cmd.load_limit  = 1'b1;
					state_d         = S_NORM;
				end else if (st.short_win) begin
					cmd.status_code = ST_SHORT;
					cmd.load_limit  = 1'b1;
					state_d         = S_NORM;
				end else begin
					cmd.status_code = ST_COMPUTED;
					state_d         = S_MINW;
				end
			end
			S_MINW: begin
				cmd.load_minw = 1'b1;
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_AVG;
				state_d       = S_AVG;
			end
			S_AVG: begin
				if (st.div_done) begin
					cmd.load_avg = 1'b1;
					state_d      = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul_step = 1'b1;
				if (mul_q == 4'd15)
					state_d = S_DIVGO;
			end
			S_DIVGO: begin
				cmd.div_sel   = DIV_NUM;
				cmd.div_start = 1'b1;
				state_d       = S_DIVN;
			end
			S_DIVN: begin
				cmd.div_sel = DIV_NUM;
				if (st.div_done) begin
					cmd.load_nt = 1'b1;
					state_d     = S_FLOOR;
				end
			end
			S_FLOOR: begin
				cmd.floor_calc = 1'b1;
				state_d        = S_CLAMP;
			end
			S_CLAMP: begin
				cmd.clamp = 1'b1;
				state_d   = S_NORM;
			end
			S_NORM: begin
				if (st.norm_done) begin
					cmd.load_out = 1'b1;
					state_d      = S_OUT;
				end else begin
					cmd.norm_step = 1'b1;
				end
			end
			S_OUT: begin
				if (m_tready)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mul_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_MUL)
				mul_q <= mul_q + 4'd1;
			else
				mul_q <= '0;
		end
	end

`ifndef SYNTHESIS
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register not one-hot");
	a_last_prep: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && action && last) |=> (state_q == S_PREP))
		else $error("last block did not start a result");
	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		st.div_done |-> (state_q == S_AVG || state_q == S_DIVN))
		else $error("divider finished outside a wait state");
`endif

endmodule
